>>> rtl/rkit_pkg.sv
// Shared types and codes for the reference-counted key intern table.
// Used by rkit_ctrl, rkit_dp, refcounted_key_intern_table_top and rkit_checker.
package rkit_pkg;

   localparam int KEY_W     = 64;
   localparam int IDX_OUT_W = 6;
   localparam int CNT_OUT_W = 16;
   localparam int STATUS_W  = 3;
   localparam int CLASS_W   = 2;
   localparam int KIND_W    = 2;

   // request kinds
   localparam logic [KIND_W-1:0] K_ASSIGN = 2'd0;
   localparam logic [KIND_W-1:0] K_FREE   = 2'd1;
   localparam logic [KIND_W-1:0] K_LOOKUP = 2'd2;
   localparam logic [KIND_W-1:0] K_QUERY  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd5;

   // index / result classes
   localparam logic [CLASS_W-1:0] CL_ORDINARY  = 2'd0;
   localparam logic [CLASS_W-1:0] CL_WILDCARD  = 2'd1;
   localparam logic [CLASS_W-1:0] CL_NOTFOUND  = 2'd2;
   localparam logic [CLASS_W-1:0] CL_LOCALHOST = 2'd3;

   // name classes
   localparam logic [CLASS_W-1:0] NC_WILDCARD  = 2'd1;
   localparam logic [CLASS_W-1:0] NC_LOCALHOST = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_SCAN   = 5'b00100,
      S_FINISH = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

   typedef struct packed {
      logic accept;
      logic decode;
      logic scan;
      logic finish;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic dec_scan;
      logic dec_finish;
      logic scan_done;
      logic out_free;
   } sts_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [IDX_OUT_W-1:0] index;
      logic [CLASS_W-1:0]   cls;
      logic [KEY_W-1:0]     key;
      logic [CNT_OUT_W-1:0] count;
   } res_type;

endpackage

>>> rtl/rkit_ctrl.sv
// Sequencer of the intern table: accept, decode, scan, finish, respond.
// Depends on rkit_pkg for the state, command and status types.
module rkit_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rkit_pkg::sts_type sts,
   output rkit_pkg::cmd_type cmd
);
   import rkit_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (sts.dec_scan)        state_in = S_SCAN;
            else if (sts.dec_finish) state_in = S_FINISH;
            else                     state_in = S_RESP;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            // hold until the output register can take the beat
            cmd.emit = sts.out_free;
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> rtl/rkit_dp.sv
// Datapath of the intern table: request latch, entry memory, scan, update, output register.
// Depends on rkit_pkg; driven by rkit_ctrl through cmd_type / sts_type.
module rkit_dp #(
   parameter int TABLE_DEPTH = 64,
   parameter int COUNT_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rkit_pkg::cmd_type               cmd,
   output rkit_pkg::sts_type               sts,
   input  logic [rkit_pkg::KIND_W-1:0]     req_kind,
   input  logic [rkit_pkg::KEY_W-1:0]      req_name_key,
   input  logic [rkit_pkg::CLASS_W-1:0]    req_name_class,
   input  logic [rkit_pkg::IDX_OUT_W-1:0]  req_node_index,
   input  logic [rkit_pkg::CLASS_W-1:0]    req_index_class,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rkit_pkg::res_type               rsp_res
);
   import rkit_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int USZ_W = $clog2(TABLE_DEPTH + 1);
   localparam int CW    = (USZ_W > IDX_OUT_W) ? USZ_W : IDX_OUT_W;
   localparam int ENT_W = KEY_W + COUNT_BITS;

   // latched request
   logic [KIND_W-1:0]    kind_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [CLASS_W-1:0]   ncls_ff;
   logic [IDX_OUT_W-1:0] idx_ff;
   logic [CLASS_W-1:0]   icls_ff;

   // entry memory: {key, count}
   logic [ENT_W-1:0] mem [TABLE_DEPTH];
   logic [ENT_W-1:0] rd_data_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENT_W-1:0] wr_data;

   logic [USZ_W-1:0]      used_ff, used_in;
   logic [USZ_W-1:0]      ptr_ff, ptr_in;
   logic [IDX_W-1:0]      chk_ff, chk_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic                  empty_ff, empty_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;

   res_type res_ff, res_in;
   res_type dec_res, fin_res;
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_res_ff;

   logic [KEY_W-1:0]      rd_key;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic                  is_name_op;
   logic                  idx_ok;
   logic                  live, match, last;
   logic [COUNT_BITS-1:0] cnt_inc, cnt_dec;
   logic                  dec_scan, dec_finish, scan_done, out_free;

   assign rd_key     = rd_data_ff[ENT_W-1:COUNT_BITS];
   assign rd_cnt     = rd_data_ff[COUNT_BITS-1:0];
   assign is_name_op = (kind_ff == K_ASSIGN) || (kind_ff == K_LOOKUP);
   assign idx_ok     = (icls_ff == CL_ORDINARY) && (CW'(idx_ff) < CW'(used_ff));
   assign live       = (rd_cnt != '0);
   assign match      = live && (rd_key == key_ff);
   assign last       = (USZ_W'(chk_ff) + USZ_W'(1)) == used_ff;
   assign cnt_inc    = hit_cnt_ff + COUNT_BITS'(1);
   assign cnt_dec    = rd_cnt - COUNT_BITS'(1);

   // decode: special classes resolve at once
   always_comb begin
      dec_res    = '0;
      dec_scan   = 1'b0;
      dec_finish = 1'b0;
      case (kind_ff)
         K_ASSIGN, K_LOOKUP: begin
            if (ncls_ff == NC_WILDCARD)       dec_res.cls = CL_WILDCARD;
            else if (ncls_ff == NC_LOCALHOST) dec_res.cls = CL_LOCALHOST;
            else if (used_ff != '0)           dec_scan = 1'b1;
            else                              dec_finish = 1'b1;
         end
         K_FREE: begin
            if (icls_ff == CL_WILDCARD) dec_res.cls = CL_WILDCARD;
            else if (!idx_ok)           dec_res.status = ST_INVALID;
            else                        dec_finish = 1'b1;
         end
         K_QUERY: begin
            if (icls_ff == CL_WILDCARD) begin
               dec_res.cls = CL_WILDCARD;
            end else if (icls_ff == CL_NOTFOUND) begin
               dec_res.status = ST_NOTFOUND;
               dec_res.cls    = CL_NOTFOUND;
            end else if (!idx_ok) begin
               dec_res.status = ST_INVALID;
            end else begin
               dec_finish = 1'b1;
            end
         end
         default: dec_res = '0;
      endcase
   end

   // memory read port
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (cmd.decode) begin
         rd_en   = 1'b1;
         rd_addr = is_name_op ? '0 : IDX_W'(idx_ff);
      end else if (cmd.scan) begin
         rd_en   = (ptr_ff < used_ff);
         rd_addr = ptr_ff[IDX_W-1:0];
      end
   end

   assign scan_done = match || last;

   // scan bookkeeping
   always_comb begin
      ptr_in     = ptr_ff;
      chk_in     = chk_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_cnt_in = hit_cnt_ff;
      empty_in   = empty_ff;
      slot_in    = slot_ff;
      if (cmd.decode) begin
         ptr_in   = USZ_W'(1);
         chk_in   = '0;
         hit_in   = 1'b0;
         empty_in = 1'b0;
      end else if (cmd.scan) begin
         ptr_in = ptr_ff + USZ_W'(1);
         chk_in = chk_ff + IDX_W'(1);
         // remember the first empty slot below the used size
         if (!live && !empty_ff) begin
            empty_in = 1'b1;
            slot_in  = chk_ff;
         end
         if (match) begin
            hit_in     = 1'b1;
            hit_idx_in = chk_ff;
            hit_cnt_in = rd_cnt;
         end
      end
   end

   // finish: build the result and apply the update
   always_comb begin
      fin_res = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      used_in = used_ff;
      if (cmd.finish) begin
         case (kind_ff)
            K_ASSIGN: begin
               if (hit_ff) begin
                  fin_res.index = IDX_OUT_W'(hit_idx_ff);
                  if (&hit_cnt_ff) begin
                     fin_res.status = ST_SATURATED;
                     fin_res.count  = CNT_OUT_W'(hit_cnt_ff);
                  end else begin
                     fin_res.count = CNT_OUT_W'(cnt_inc);
                     wr_en         = 1'b1;
                     wr_addr       = hit_idx_ff;
                     wr_data       = {key_ff, cnt_inc};
                  end
               end else if (empty_ff) begin
                  fin_res.index = IDX_OUT_W'(slot_ff);
                  fin_res.count = CNT_OUT_W'(1);
                  wr_en         = 1'b1;
                  wr_addr       = slot_ff;
                  wr_data       = {key_ff, COUNT_BITS'(1)};
               end else if (used_ff == USZ_W'(TABLE_DEPTH)) begin
                  fin_res.status = ST_OVERFLOW;
                  fin_res.cls    = CL_NOTFOUND;
               end else begin
                  // append at the used size
                  fin_res.index = IDX_OUT_W'(used_ff);
                  fin_res.count = CNT_OUT_W'(1);
                  wr_en         = 1'b1;
                  wr_addr       = used_ff[IDX_W-1:0];
                  wr_data       = {key_ff, COUNT_BITS'(1)};
                  used_in       = used_ff + USZ_W'(1);
               end
            end
            K_LOOKUP: begin
               if (hit_ff) begin
                  fin_res.index = IDX_OUT_W'(hit_idx_ff);
                  fin_res.count = CNT_OUT_W'(hit_cnt_ff);
               end else begin
                  fin_res.status = ST_NOTFOUND;
                  fin_res.cls    = CL_NOTFOUND;
               end
            end
            K_FREE: begin
               fin_res.index = idx_ff;
               if (!live) begin
                  fin_res.status = ST_FREED;
               end else begin
                  fin_res.count = CNT_OUT_W'(cnt_dec);
                  wr_en         = 1'b1;
                  wr_addr       = IDX_W'(idx_ff);
                  wr_data       = {rd_key, cnt_dec};
                  // shrink only when the last entry empties
                  if (cnt_dec == '0 && (CW'(idx_ff) + CW'(1)) == CW'(used_ff))
                     used_in = used_ff - USZ_W'(1);
               end
            end
            K_QUERY: begin
               fin_res.index = idx_ff;
               if (!live) begin
                  fin_res.status = ST_FREED;
               end else begin
                  fin_res.key   = rd_key;
                  fin_res.count = CNT_OUT_W'(rd_cnt);
               end
            end
            default: fin_res = '0;
         endcase
      end
   end

   always_comb begin
      res_in = res_ff;
      if (cmd.decode)      res_in = dec_res;
      else if (cmd.finish) res_in = fin_res;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign sts = {dec_scan, dec_finish, scan_done, out_free};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_kind;
         key_ff  <= req_name_key;
         ncls_ff <= req_name_class;
         idx_ff  <= req_node_index;
         icls_ff <= req_index_class;
      end
      ptr_ff     <= ptr_in;
      chk_ff     <= chk_in;
      hit_idx_ff <= hit_idx_in;
      hit_cnt_ff <= hit_cnt_in;
      slot_ff    <= slot_in;
      res_ff     <= res_in;
      if (cmd.emit) rsp_res_ff <= res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         hit_ff       <= 1'b0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         hit_ff       <= hit_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_res_ff;

endmodule

>>> rtl/refcounted_key_intern_table_top.sv
// Top level of the reference-counted key intern table.
// Depends on rkit_pkg, rkit_ctrl and rkit_dp.
//
//   channel | direction | beat contents
//   --------+-----------+---------------------------------------------------------
//   req_    | in        | kind, name_key, name_class, node_index, index_class
//   rsp_    | out       | status, result_index, result_class, result_key, result_count
//
// Sequence: one request at a time. Free and query of an index below the used size
// pass through accept, decode, finish and respond; special classes and rejected
// indexes skip the update and go from decode straight to respond. Assign and lookup
// walk the entry memory one entry a cycle (one read port), up to the used size,
// then finish and respond. A hit ends the walk early.
// Reset: synchronous; clears the used size and the handshake state. The entry
// memory needs no clearing pass: no word at or above the used size is ever used.
// Stalls: a response waits in the output register while rsp_ready is low; the
// block accepts the next request meanwhile and holds its result until the
// output register frees up.
module refcounted_key_intern_table_top #(
   parameter int TABLE_DEPTH = 64,
   parameter int COUNT_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rkit_pkg::KIND_W-1:0]     req_kind,
   input  logic [rkit_pkg::KEY_W-1:0]      req_name_key,
   input  logic [rkit_pkg::CLASS_W-1:0]    req_name_class,
   input  logic [rkit_pkg::IDX_OUT_W-1:0]  req_node_index,
   input  logic [rkit_pkg::CLASS_W-1:0]    req_index_class,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rkit_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rkit_pkg::IDX_OUT_W-1:0]  rsp_result_index,
   output logic [rkit_pkg::CLASS_W-1:0]    rsp_result_class,
   output logic [rkit_pkg::KEY_W-1:0]      rsp_result_key,
   output logic [rkit_pkg::CNT_OUT_W-1:0]  rsp_result_count
);
   import rkit_pkg::*;

   cmd_type cmd;
   sts_type sts;
   res_type rsp_res;

   // sequencer: owns the handshake on the request side
   rkit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: entry memory, scan and output register
   rkit_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_kind),
      .req_name_key    (req_name_key),
      .req_name_class  (req_name_class),
      .req_node_index  (req_node_index),
      .req_index_class (req_index_class),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_res         (rsp_res)
   );

   // unpack the response beat onto its ports
   assign rsp_status       = rsp_res.status;
   assign rsp_result_index = rsp_res.index;
   assign rsp_result_class = rsp_res.cls;
   assign rsp_result_key   = rsp_res.key;
   assign rsp_result_count = rsp_res.count;

endmodule

>>> rtl/rkit_checker.sv
// Port-level checks for the intern table, bound to the top level.
// Depends on rkit_pkg and refcounted_key_intern_table_top.
module rkit_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [rkit_pkg::STATUS_W-1:0]   rsp_status,
   input logic [rkit_pkg::CLASS_W-1:0]    rsp_result_class,
   input logic [rkit_pkg::CNT_OUT_W-1:0]  rsp_result_count
);
   import rkit_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_count))
      else $error("response beat changed while stalled");

   // one request in flight: ready drops after an accepted beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_notfound_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NOTFOUND || rsp_status == ST_OVERFLOW)
         |-> rsp_result_class == CL_NOTFOUND && rsp_result_count == '0)
      else $error("miss or overflow without notfound class");

   a_freed_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FREED |-> rsp_result_count == '0)
      else $error("freed entry reported with nonzero count");

endmodule

bind refcounted_key_intern_table_top rkit_checker u_rkit_checker (.*);

>>> tb/rkit_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the reference-counted key intern table: a shadow table that
// predicts each response beat and checks the block's beats in order.
// Depends on rkit_pkg for the request kinds, status codes and class codes.
package rkit_tb_pkg;
   import rkit_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int COUNT_BITS  = 16;
   localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
   localparam logic [CLASS_W-1:0] NC_ORDINARY = 2'd0;
   localparam logic [CLASS_W-1:0] NC_SPARE    = 2'd3;

   class intern_scoreboard;
      logic [KEY_W-1:0] slot_key[TABLE_DEPTH];
      int unsigned      slot_count[TABLE_DEPTH];
      int unsigned      used_size;
      res_type          due_replies[$];
      int unsigned      replies_seen;
      int unsigned      mismatches;

      function new();
         foreach (slot_key[i]) begin
            slot_key[i]   = '0;
            slot_count[i] = 0;
         end
         used_size    = 0;
         replies_seen = 0;
         mismatches   = 0;
      endfunction

      function res_type make_reply(logic [STATUS_W-1:0] st, int unsigned idx,
                                   logic [CLASS_W-1:0] cls, logic [KEY_W-1:0] key,
                                   int unsigned cnt);
         res_type r;
         r.status = st;
         r.index  = idx[IDX_OUT_W-1:0];
         r.cls    = cls;
         r.key    = key;
         r.count  = cnt[CNT_OUT_W-1:0];
         return r;
      endfunction

      // Bump a live match (unless saturated), else take the first hole below used_size, else append or overflow.
      function res_type predict_assign(logic [KEY_W-1:0] key, logic [CLASS_W-1:0] ncls);
         int unsigned i;
         int unsigned slot;
         bit          have_empty;
         if (ncls == NC_WILDCARD) return make_reply(ST_OK, 0, CL_WILDCARD, '0, 0);
         if (ncls == NC_LOCALHOST) return make_reply(ST_OK, 0, CL_LOCALHOST, '0, 0);
         have_empty = 1'b0;
         slot       = 0;
         for (i = 0; i < used_size; i++) begin
            if (slot_count[i] == 0) begin
               if (!have_empty) begin
                  have_empty = 1'b1;
                  slot       = i;
               end
            end else if (slot_key[i] == key) begin
               if (slot_count[i] >= COUNT_MAX)
                  return make_reply(ST_SATURATED, i, CL_ORDINARY, '0, slot_count[i]);
               slot_count[i]++;
               return make_reply(ST_OK, i, CL_ORDINARY, '0, slot_count[i]);
            end
         end
         if (!have_empty) begin
            if (used_size >= TABLE_DEPTH) return make_reply(ST_OVERFLOW, 0, CL_NOTFOUND, '0, 0);
            slot = used_size;
            used_size++;
         end
         slot_key[slot]   = key;
         slot_count[slot] = 1;
         return make_reply(ST_OK, slot, CL_ORDINARY, '0, 1);
      endfunction

      // Shrink used_size only when the top entry empties.
      function res_type predict_free(int unsigned idx, logic [CLASS_W-1:0] icls);
         if (icls == CL_WILDCARD) return make_reply(ST_OK, 0, CL_WILDCARD, '0, 0);
         if (icls != CL_ORDINARY || idx >= used_size)
            return make_reply(ST_INVALID, 0, CL_ORDINARY, '0, 0);
         if (slot_count[idx] == 0) return make_reply(ST_FREED, idx, CL_ORDINARY, '0, 0);
         slot_count[idx]--;
         if (slot_count[idx] == 0 && idx + 1 == used_size) used_size--;
         return make_reply(ST_OK, idx, CL_ORDINARY, '0, slot_count[idx]);
      endfunction

      function res_type predict_lookup(logic [KEY_W-1:0] key, logic [CLASS_W-1:0] ncls);
         int unsigned i;
         if (ncls == NC_WILDCARD) return make_reply(ST_OK, 0, CL_WILDCARD, '0, 0);
         if (ncls == NC_LOCALHOST) return make_reply(ST_OK, 0, CL_LOCALHOST, '0, 0);
         for (i = 0; i < used_size; i++)
            if (slot_count[i] != 0 && slot_key[i] == key)
               return make_reply(ST_OK, i, CL_ORDINARY, '0, slot_count[i]);
         return make_reply(ST_NOTFOUND, 0, CL_NOTFOUND, '0, 0);
      endfunction

      function res_type predict_query(int unsigned idx, logic [CLASS_W-1:0] icls);
         if (icls == CL_WILDCARD) return make_reply(ST_OK, 0, CL_WILDCARD, '0, 0);
         if (icls == CL_NOTFOUND) return make_reply(ST_NOTFOUND, 0, CL_NOTFOUND, '0, 0);
         if (icls != CL_ORDINARY || idx >= used_size)
            return make_reply(ST_INVALID, 0, CL_ORDINARY, '0, 0);
         if (slot_count[idx] == 0) return make_reply(ST_FREED, idx, CL_ORDINARY, '0, 0);
         return make_reply(ST_OK, idx, CL_ORDINARY, slot_key[idx], slot_count[idx]);
      endfunction

      function void log_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                logic [CLASS_W-1:0] ncls, logic [IDX_OUT_W-1:0] idx,
                                logic [CLASS_W-1:0] icls);
         res_type r;
         case (kind)
            K_ASSIGN: r = predict_assign(key, ncls);
            K_FREE:   r = predict_free(idx, icls);
            K_LOOKUP: r = predict_lookup(key, ncls);
            default:  r = predict_query(idx, icls);
         endcase
         due_replies.push_back(r);
      endfunction

      function void compare_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: reply %0d %s expected %0h got %0h",
                     $time, replies_seen, name, want, got);
         end
      endfunction

      function void check_reply(res_type got);
         res_type want;
         replies_seen++;
         if (due_replies.size() == 0) begin
            mismatches++;
            $display("%0t: reply %0d expected nothing got status %0h",
                     $time, replies_seen, got.status);
            return;
         end
         want = due_replies.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("result_index", want.index, got.index);
         compare_field("result_class", want.cls, got.cls);
         compare_field("result_key", want.key, got.key);
         compare_field("result_count", want.count, got.count);
      endfunction

      function int pending();
         return due_replies.size();
      endfunction
   endclass

endpackage

>>> tb/tb_refcounted_key_intern_table_top.sv
`timescale 1ns / 1ps
// Testbench top for refcounted_key_intern_table_top: clock, reset, request
// driver, stalling response sink, beat monitor and the end-of-run verdict.
// Depends on rkit_pkg, rkit_tb_pkg and the RTL of the block.
module tb_refcounted_key_intern_table_top;
   import rkit_pkg::*;
   import rkit_tb_pkg::*;

   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int RANDOM_ITEMS    = 1050;
   localparam int FILL_ITEMS      = 70;
   localparam int SEGMENT_ITEMS   = 196;
   localparam int POOL_SIZE       = 80;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES   = TABLE_DEPTH + 8;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic [KIND_W-1:0]    req_kind        = K_ASSIGN;
   logic [KEY_W-1:0]     req_name_key    = '0;
   logic [CLASS_W-1:0]   req_name_class  = NC_ORDINARY;
   logic [IDX_OUT_W-1:0] req_node_index  = '0;
   logic [CLASS_W-1:0]   req_index_class = CL_ORDINARY;
   logic                 rsp_valid;
   logic                 rsp_ready       = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [IDX_OUT_W-1:0] rsp_result_index;
   logic [CLASS_W-1:0]   rsp_result_class;
   logic [KEY_W-1:0]     rsp_result_key;
   logic [CNT_OUT_W-1:0] rsp_result_count;

   // idle_on lets both sides insert random gaps; hold_rsp asks the sink for a
   // long hold-off while the driver keeps offering requests
   bit               idle_on     = 1'b1;
   bit               hold_rsp    = 1'b0;
   int unsigned      cycle_count = 0;
   int unsigned      sent_count  = 0;
   intern_scoreboard sb;
   logic [KEY_W-1:0] key_pool[POOL_SIZE];

   refcounted_key_intern_table_top #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_name_key    (req_name_key),
      .req_name_class  (req_name_class),
      .req_node_index  (req_node_index),
      .req_index_class (req_index_class),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_result_index(rsp_result_index),
      .rsp_result_class(rsp_result_class),
      .rsp_result_key  (rsp_result_key),
      .rsp_result_count(rsp_result_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Monitor: sample both channels at the edge, log the request beat first so
   // the prediction queue stays in order, then check any response beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.log_request(req_kind, req_name_key, req_name_class, req_node_index,
                           req_index_class);
         if (rsp_valid && rsp_ready)
            sb.check_reply({rsp_status, rsp_result_index, rsp_result_class,
                            rsp_result_key, rsp_result_count});
      end
   end

   // Response sink: drop ready in about a third of the cycles while idling is
   // on; on request, hold ready low for a long stretch so the block backs up.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= !idle_on || $urandom_range(0, 99) >= 32;
      end
   end

   // Abort a hung run.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   // Offer one request beat, maybe after a random gap, and hold it until taken.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                            input logic [CLASS_W-1:0] ncls,
                            input logic [IDX_OUT_W-1:0] idx,
                            input logic [CLASS_W-1:0] icls);
      if (idle_on && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_name_key    <= key;
      req_name_class  <= ncls;
      req_node_index  <= idx;
      req_index_class <= icls;
      sent_count++;
      do @(posedge clock); while (!req_ready);
   endtask

   // Pause the driver until every sent request has been answered.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (sb.replies_seen < sent_count) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [KEY_W-1:0]     key;
      logic [KIND_W-1:0]    kind;
      logic [CLASS_W-1:0]   ncls;
      logic [CLASS_W-1:0]   icls;
      logic [IDX_OUT_W-1:0] idx;
      int unsigned          roll;
      bit                   grow;
      int                   n;

      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-table misses, key extremes, every special class on
      // both sides, name class three as ordinary, freed-entry access,
      // hole reuse and used-size shrink when the top entry empties.
      send_item(K_LOOKUP, '0, NC_ORDINARY, 0, CL_ORDINARY);
      send_item(K_QUERY, rand_key(), NC_ORDINARY, 0, CL_ORDINARY);
      send_item(K_FREE, rand_key(), NC_ORDINARY, 0, CL_ORDINARY);
      send_item(K_ASSIGN, '0, NC_ORDINARY, '1, CL_LOCALHOST);
      send_item(K_ASSIGN, '1, NC_ORDINARY, 0, CL_ORDINARY);
      send_item(K_ASSIGN, '0, NC_ORDINARY, 0, CL_ORDINARY);
      send_item(K_ASSIGN, rand_key(), NC_WILDCARD, 0, CL_ORDINARY);
      send_item(K_ASSIGN, rand_key(), NC_LOCALHOST, 0, CL_ORDINARY);
      send_item(K_LOOKUP, rand_key(), NC_WILDCARD, 0, CL_ORDINARY);
      send_item(K_LOOKUP, rand_key(), NC_LOCALHOST, 0, CL_ORDINARY);
      send_item(K_ASSIGN, '1, NC_SPARE, 0, CL_ORDINARY);
      send_item(K_LOOKUP, '0, NC_SPARE, 0, CL_ORDINARY);
      send_item(K_QUERY, rand_key(), NC_ORDINARY, 1, CL_ORDINARY);
      send_item(K_QUERY, rand_key(), NC_ORDINARY, 1, CL_WILDCARD);
      send_item(K_QUERY, rand_key(), NC_ORDINARY, 1, CL_NOTFOUND);
      send_item(K_QUERY, rand_key(), NC_ORDINARY, 1, CL_LOCALHOST);
      send_item(K_FREE, rand_key(), NC_ORDINARY, 1, CL_WILDCARD);
      send_item(K_FREE, rand_key(), NC_ORDINARY, 1, CL_NOTFOUND);
      send_item(K_FREE, rand_key(), NC_ORDINARY, 1, CL_LOCALHOST);
      send_item(K_QUERY, rand_key(), NC_ORDINARY, '1, CL_ORDINARY);
      repeat (2) send_item(K_FREE, rand_key(), NC_ORDINARY, 0, CL_ORDINARY);
      send_item(K_QUERY, rand_key(), NC_ORDINARY, 0, CL_ORDINARY);
      send_item(K_FREE, rand_key(), NC_ORDINARY, 0, CL_ORDINARY);
      send_item(K_ASSIGN, 64'h5555_5555_5555_5555, NC_ORDINARY, 0, CL_ORDINARY);
      repeat (2) send_item(K_FREE, rand_key(), NC_ORDINARY, 1, CL_ORDINARY);
      send_item(K_LOOKUP, '1, NC_ORDINARY, 0, CL_ORDINARY);

      // Random: first fill the table with fresh keys until it overflows, then
      // alternate drain-heavy and growth-heavy segments over a key pool small
      // enough to hit often and large enough to overflow again.
      foreach (key_pool[i]) key_pool[i] = rand_key();
      key_pool[0]           = '0;
      key_pool[POOL_SIZE-1] = '1;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) hold_rsp = 1'b1;
         if (n == 600) drain_replies();
         idle_on = !(n >= 800 && n < 900);

         // start from noise in every field, then shape the ones that matter
         key  = rand_key();
         ncls = $urandom_range(0, 3);
         idx  = $urandom_range(0, 63);
         icls = $urandom_range(0, 3);
         if (n < FILL_ITEMS) begin
            kind = K_ASSIGN;
            key  = key_pool[n];
            ncls = NC_ORDINARY;
         end else begin
            grow = ((n - FILL_ITEMS) / SEGMENT_ITEMS) % 2 == 1;
            roll = $urandom_range(0, 99);
            if (roll < (grow ? 60 : 15))
               kind = K_ASSIGN;
            else if (roll < (grow ? 72 : 70))
               kind = K_FREE;
            else if (roll < 86)
               kind = K_LOOKUP;
            else
               kind = K_QUERY;
            if ($urandom_range(0, 9) != 0) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 7) != 0) ncls = NC_ORDINARY;
            if ($urandom_range(0, 6) != 0)
               idx = $urandom_range(0, sb.used_size == 0 ? 0 : sb.used_size - 1);
            if ($urandom_range(0, 7) != 0) icls = CL_ORDINARY;
         end
         send_item(kind, key, ncls, idx, icls);
      end

      // Wrap up: wait for the last beat, then linger to catch strays.
      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
